// ----- src/line_box_slab_intersect_defines.svh -----
// Assertion macros for the slab intersect block
`ifndef LINE_BOX_SLAB_INTERSECT_DEFINES_SVH
`define LINE_BOX_SLAB_INTERSECT_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define LBSI_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define LBSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- src/lbsi_pkg.sv -----
`timescale 1ns / 1ps
package lbsi_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int CSR_IDX_W     = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_Z = 3'd5;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] t_enter;
      logic signed [31:0] t_leave;
   } rsp_type;

endpackage

// ----- src/lbsi_div.sv -----
`timescale 1ns / 1ps
// Pipelined unsigned restoring divider: NUM_W-bit numerator by 32-bit
// divisor, STEP_BITS quotient bits per stage. Sideband rides along.
module lbsi_div #(
   parameter int NUM_W     = 49,
   parameter int STEP_BITS = 4,
   parameter int SB_W      = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [31:0]      in_den,
   input  logic [SB_W-1:0]  in_sb,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quo,
   output logic [SB_W-1:0]  out_sb
);
   localparam int STAGES = (NUM_W + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_W  = STAGES * STEP_BITS;

   logic             vld_ff [STAGES+1];
   logic [PAD_W-1:0] num_ff [STAGES+1];
   logic [32:0]      rem_ff [STAGES+1];
   logic [31:0]      den_ff [STAGES+1];
   logic [SB_W-1:0]  sb_ff  [STAGES+1];

   // stage 0 capture
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
      if (en) begin
         num_ff[0] <= PAD_W'(in_num);
         rem_ff[0] <= '0;
         den_ff[0] <= in_den;
         sb_ff[0]  <= in_sb;
      end
   end

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [32:0]      rem_in;
      logic [PAD_W-1:0] num_in;
      always_comb begin
         logic [33:0] trial;
         rem_in = rem_ff[s];
         num_in = num_ff[s];
         for (int b = 0; b < STEP_BITS; b++) begin
            trial  = {rem_in, num_in[PAD_W-1]};
            num_in = {num_in[PAD_W-2:0], 1'b0};
            if (trial >= {2'b00, den_ff[s]}) begin
               rem_in    = 33'(trial - {2'b00, den_ff[s]});
               num_in[0] = 1'b1;
            end else begin
               rem_in = trial[32:0];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (en) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         if (en) begin
            num_ff[s+1] <= num_in;
            rem_ff[s+1] <= rem_in;
            den_ff[s+1] <= den_ff[s];
            sb_ff[s+1]  <= sb_ff[s];
         end
      end
   end

   assign out_valid = vld_ff[STAGES];
   assign out_quo   = num_ff[STAGES][NUM_W-1:0];
   assign out_sb    = sb_ff[STAGES];
endmodule

// ----- src/line_box_slab_intersect.sv -----
`timescale 1ns / 1ps
// Channel  Ports                       Beat
// req      req_valid/ready, req_data   line origin and direction
// rsp      rsp_valid/ready, rsp_data   hit flag, t_enter, t_leave
// csr      csr_valid/ready, csr_index  box corner register write
//
// One beat per cycle when rsp is not stalled; the six parallel pipelined
// dividers (4 quotient bits per stage) sit between stage 1 and stage 3.
// Synchronous reset clears valid bits and box registers to zero.
// A stall at rsp freezes the whole pipeline; req_ready follows it.
`include "line_box_slab_intersect_defines.svh"
module line_box_slab_intersect #(
   parameter int FRAC_BITS = lbsi_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  lbsi_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output lbsi_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lbsi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_data
);
   localparam int NUM_W = 33 + FRAC_BITS;   // |diff| << FRAC_BITS
   localparam int Q_W   = NUM_W + 1;        // signed quotient

   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   // box registers
   logic signed [31:0] bmin_ff [3];
   logic signed [31:0] bmax_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            bmin_ff[a] <= '0;
            bmax_ff[a] <= '0;
         end
      end else if (csr_valid) begin
         case (csr_index)
            lbsi_pkg::REG_MIN_X: bmin_ff[0] <= csr_data;
            lbsi_pkg::REG_MIN_Y: bmin_ff[1] <= csr_data;
            lbsi_pkg::REG_MIN_Z: bmin_ff[2] <= csr_data;
            lbsi_pkg::REG_MAX_X: bmax_ff[0] <= csr_data;
            lbsi_pkg::REG_MAX_Y: bmax_ff[1] <= csr_data;
            lbsi_pkg::REG_MAX_Z: bmax_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // stage 1: differences, signs, parallel misses
   logic signed [31:0] o_w [3];
   logic signed [31:0] d_w [3];
   assign o_w[0] = req_data.origin_x;
   assign o_w[1] = req_data.origin_y;
   assign o_w[2] = req_data.origin_z;
   assign d_w[0] = req_data.dir_x;
   assign d_w[1] = req_data.dir_y;
   assign d_w[2] = req_data.dir_z;

   logic              s1_vld_ff;
   logic              s1_miss_ff;
   logic [2:0]        s1_par_ff;
   logic [2:0]        s1_dneg_ff;
   logic signed [32:0] s1_dlo_ff [3];
   logic signed [32:0] s1_dhi_ff [3];
   logic [31:0]       s1_dmag_ff [3];
   logic              miss_in;
   always_comb begin
      miss_in = 1'b0;
      for (int a = 0; a < 3; a++) begin
         if (d_w[a] == '0 && (o_w[a] < bmin_ff[a] || o_w[a] > bmax_ff[a])) begin
            miss_in = 1'b1;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_valid;
      end
      if (en) begin
         s1_miss_ff <= miss_in;
         for (int a = 0; a < 3; a++) begin
            s1_par_ff[a]  <= d_w[a] == '0;
            s1_dneg_ff[a] <= d_w[a][31];
            s1_dlo_ff[a]  <= 33'(bmin_ff[a]) - 33'(o_w[a]);
            s1_dhi_ff[a]  <= 33'(bmax_ff[a]) - 33'(o_w[a]);
            s1_dmag_ff[a] <= d_w[a][31] ? 32'(-d_w[a]) : d_w[a];
         end
      end
   end

   // stage 2: magnitudes of numerators, quotient signs
   logic [NUM_W-1:0] s2_num [6];
   logic [31:0]      s2_den [6];
   logic [5:0]       s2_neg;
   always_comb begin
      logic signed [32:0] df;
      for (int k = 0; k < 6; k++) begin
         df        = (k < 3) ? s1_dlo_ff[k % 3] : s1_dhi_ff[k % 3];
         s2_num[k] = NUM_W'(df[32] ? 33'(-df) : df) << FRAC_BITS;
         s2_den[k] = s1_dmag_ff[k % 3];
         s2_neg[k] = df[32] ^ s1_dneg_ff[k % 3];
      end
   end

   localparam int SB_W = 1 + 1 + 3 + 3 + 6;
   logic            dv_vld [6];
   logic [NUM_W-1:0] dv_q  [6];
   logic [SB_W-1:0] dv_sb  [6];
   for (genvar k = 0; k < 6; k++) begin : g_div
      lbsi_div #(.NUM_W(NUM_W), .STEP_BITS(4), .SB_W(SB_W)) u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (s1_vld_ff),
         .in_num    (s2_num[k]),
         .in_den    (s2_den[k]),
         .in_sb     ({s1_vld_ff, s1_miss_ff, s1_par_ff, s1_dneg_ff, s2_neg}),
         .out_valid (dv_vld[k]),
         .out_quo   (dv_q[k]),
         .out_sb    (dv_sb[k])
      );
   end

   // stage 3: signed quotients, enter/leave per axis
   logic [2:0] sb_par;
   logic [2:0] sb_dneg;
   logic [5:0] sb_neg;
   assign sb_par  = dv_sb[0][11:9];
   assign sb_dneg = dv_sb[0][8:6];
   assign sb_neg  = dv_sb[0][5:0];

   logic               s3_vld_ff;
   logic               s3_miss_ff;
   logic [2:0]         s3_par_ff;
   logic signed [Q_W-1:0] s3_e_ff [3];
   logic signed [Q_W-1:0] s3_l_ff [3];
   always_ff @(posedge clock) begin
      logic signed [Q_W-1:0] qlo;
      logic signed [Q_W-1:0] qhi;
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= dv_vld[0];
      end
      if (en) begin
         s3_miss_ff <= dv_sb[0][12];
         s3_par_ff  <= sb_par;
         for (int a = 0; a < 3; a++) begin
            qlo = sb_neg[a]   ? -$signed({1'b0, dv_q[a]})   : $signed({1'b0, dv_q[a]});
            qhi = sb_neg[a+3] ? -$signed({1'b0, dv_q[a+3]}) : $signed({1'b0, dv_q[a+3]});
            s3_e_ff[a] <= sb_dneg[a] ? qhi : qlo;
            s3_l_ff[a] <= sb_dneg[a] ? qlo : qhi;
         end
      end
   end

   // stage 4: max of entering, min of leaving (parallel axes skipped)
   logic                  s4_vld_ff;
   logic                  s4_miss_ff;
   logic                  s4_hase_ff;
   logic signed [Q_W-1:0] s4_e_ff;
   logic signed [Q_W-1:0] s4_l_ff;
   always_ff @(posedge clock) begin
      logic signed [Q_W-1:0] emax;
      logic signed [Q_W-1:0] lmin;
      logic                  any;
      emax = '0;
      lmin = '0;
      any  = 1'b0;
      for (int a = 0; a < 3; a++) begin
         if (!s3_par_ff[a]) begin
            if (!any || s3_e_ff[a] > emax) emax = s3_e_ff[a];
            if (!any || s3_l_ff[a] < lmin) lmin = s3_l_ff[a];
            any = 1'b1;
         end
      end
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s4_vld_ff <= s3_vld_ff;
      end
      if (en) begin
         s4_miss_ff <= s3_miss_ff;
         s4_hase_ff <= any;
         s4_e_ff    <= emax;
         s4_l_ff    <= lmin;
      end
   end

   // stage 5: compare, saturate, output register
   localparam logic signed [Q_W-1:0] QMAX = Q_W'(32'sh7fffffff);
   localparam logic signed [Q_W-1:0] QMIN = -(Q_W'(32'sh7fffffff)) - Q_W'(1);
   logic               hit_w;
   logic signed [31:0] te_w;
   logic signed [31:0] tl_w;
   always_comb begin
      hit_w = !s4_miss_ff && (!s4_hase_ff || s4_l_ff >= s4_e_ff);
      if (!s4_hase_ff || s4_e_ff < QMIN) te_w = 32'sh80000000;
      else if (s4_e_ff > QMAX)           te_w = 32'sh7fffffff;
      else                               te_w = s4_e_ff[31:0];
      if (!s4_hase_ff || s4_l_ff > QMAX) tl_w = 32'sh7fffffff;
      else if (s4_l_ff < QMIN)           tl_w = 32'sh80000000;
      else                               tl_w = s4_l_ff[31:0];
   end

   logic             rsp_vld_ff;
   lbsi_pkg::rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= s4_vld_ff;
      end
      if (en) begin
         rsp_ff.hit     <= hit_w;
         rsp_ff.t_enter <= hit_w ? te_w : '0;
         rsp_ff.t_leave <= hit_w ? tl_w : '0;
      end
   end
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `LBSI_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid && !rsp_data.hit, rsp_data.t_enter == '0 && rsp_data.t_leave == '0)
   `LBSI_ASSERT_IMP(a_hit_order, clock, reset, rsp_valid && rsp_data.hit, rsp_data.t_enter <= rsp_data.t_leave)
   `LBSI_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
endmodule
